// File: rtl/dmtm_pkg.sv
// shared types, constants and codes for the dual mean threshold mask block
package dmtm_pkg;

    localparam int VALUE_W    = 16;
    localparam int SUM_W      = 36;
    localparam int CNT_W      = 21;
    localparam int LEVEL_W    = 8;
    localparam int DENS_W     = 17;
    localparam int THR_W      = 16;
    localparam int PROD_W     = THR_W + VALUE_W;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DENS_SHIFT = 16;
    localparam int DIV_NUM_W  = CNT_W + DENS_SHIFT;
    localparam int DIV_DEN_W  = CNT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(1048576);

    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTROPY_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ZERO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE   = 2'd3;

    localparam logic [THR_W-1:0]   RST_MEASURE_THR = THR_W'(256);
    localparam logic [THR_W-1:0]   RST_ENTROPY_THR = THR_W'(256);
    localparam logic [LEVEL_W-1:0] RST_LEVEL_ZERO  = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] RST_LEVEL_ONE   = LEVEL_W'(255);

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] measure_value;
        logic [VALUE_W-1:0] entropy_value;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic [LEVEL_W-1:0] mask_level;
        logic               stats_valid;
        logic [DENS_W-1:0]  density;
        logic [VALUE_W-1:0] mask_entropy_mean;
        logic [VALUE_W-1:0] other_entropy_mean;
    } t_out_beat;

    typedef enum logic [2:0] {
        DIV_MEASURE,
        DIV_ENTROPY,
        DIV_DENSITY,
        DIV_IN_MEAN,
        DIV_OUT_MEAN
    } t_div_sel;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_LOAD,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        logic     capture;
        t_div_sel sel;
        logic     clear_acc;
        logic     emit_stats;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_ready;
    } t_status;

endpackage

// File: rtl/dmtm_div.sv
// restoring serial divider, one quotient bit per cycle, zero divisor gives zero
module dmtm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dmtm_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [dmtm_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [dmtm_pkg::DIV_NUM_W-1:0] o_quot
);
    import dmtm_pkg::*;

    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_DEN_W-1:0] r_den, n_den;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_zero, n_zero;
    logic                 r_done, n_done;
    logic [DIV_DEN_W:0]   shifted;
    logic                 fits;

    always_comb begin
        shifted = {r_rem, r_num[DIV_NUM_W-1]};
        fits    = shifted >= {1'b0, r_den};
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_zero  = r_zero;
        n_done  = 1'b0;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = '0;
            n_busy = 1'b1;
            n_zero = (i_den == '0);
        end else if (r_busy) begin
            n_rem = fits ? DIV_DEN_W'(shifted - {1'b0, r_den}) : DIV_DEN_W'(shifted);
            n_num = {r_num[DIV_NUM_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        r_zero <= n_zero;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_num;

endmodule

// File: rtl/dmtm_datapath.sv
// accumulators, means, classify compare, config registers and output register
module dmtm_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dmtm_pkg::t_cmd                  i_cmd,
    output dmtm_pkg::t_status               o_status,
    input  dmtm_pkg::t_in_beat              i_in_data,
    input  logic                            i_cfg_we,
    input  logic [dmtm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmtm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    output dmtm_pkg::t_out_beat             o_out_data,
    input  logic                            i_out_stall
);
    import dmtm_pkg::*;

    logic [THR_W-1:0]   r_mthr, r_ethr;
    logic [LEVEL_W-1:0] r_lvl0, r_lvl1;

    logic [SUM_W-1:0]   r_msum, n_msum, r_esum, n_esum;
    logic [CNT_W-1:0]   r_pcnt, n_pcnt;
    logic [VALUE_W-1:0] r_mmean, n_mmean, r_emean, n_emean;
    logic [CNT_W-1:0]   r_icnt, n_icnt, r_ccnt, n_ccnt;
    logic [SUM_W-1:0]   r_isum, n_isum, r_osum, n_osum;
    logic [DENS_W-1:0]  r_dens, n_dens;
    logic [VALUE_W-1:0] r_imean, n_imean, r_omean, n_omean;
    logic [LEVEL_W-1:0] r_last_lvl, n_last_lvl;

    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    logic [PROD_W-1:0]    mprod, eprod, mscaled, escaled;
    logic                 in_mask;
    logic [LEVEL_W-1:0]   level;
    logic                 out_ready;
    logic [DIV_NUM_W-1:0] div_num, quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;

    assign mprod   = PROD_W'(r_mthr) * PROD_W'(r_mmean);
    assign eprod   = PROD_W'(r_ethr) * PROD_W'(r_emean);
    assign mscaled = PROD_W'(i_in_data.measure_value) << FRAC_W;
    assign escaled = PROD_W'(i_in_data.entropy_value) << FRAC_W;
    assign in_mask = (mscaled >= mprod) && (escaled >= eprod);
    assign level   = in_mask ? r_lvl1 : r_lvl0;
    assign out_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_cmd.sel)
            DIV_MEASURE: begin
                div_num = DIV_NUM_W'(r_msum);
                div_den = r_pcnt;
            end
            DIV_ENTROPY: begin
                div_num = DIV_NUM_W'(r_esum);
                div_den = r_pcnt;
            end
            DIV_DENSITY: begin
                div_num = {r_icnt, {DENS_SHIFT{1'b0}}};
                div_den = r_ccnt;
            end
            DIV_IN_MEAN: begin
                div_num = DIV_NUM_W'(r_isum);
                div_den = r_icnt;
            end
            DIV_OUT_MEAN: begin
                div_num = DIV_NUM_W'(r_osum);
                div_den = r_ccnt - r_icnt;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    dmtm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        n_msum = r_msum;
        n_esum = r_esum;
        n_pcnt = r_pcnt;
        n_mmean = r_mmean;
        n_emean = r_emean;
        n_icnt = r_icnt;
        n_ccnt = r_ccnt;
        n_isum = r_isum;
        n_osum = r_osum;
        n_dens = r_dens;
        n_imean = r_imean;
        n_omean = r_omean;
        n_last_lvl = r_last_lvl;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cmd.accept) begin
            if (!i_in_data.func) begin
                if (r_pcnt < MAX_PIXELS) begin
                    n_msum = r_msum + SUM_W'(i_in_data.measure_value);
                    n_esum = r_esum + SUM_W'(i_in_data.entropy_value);
                    n_pcnt = r_pcnt + 1'b1;
                end
            end else begin
                if (r_ccnt < MAX_PIXELS) begin
                    n_ccnt = r_ccnt + 1'b1;
                    if (in_mask) begin
                        n_icnt = r_icnt + 1'b1;
                        n_isum = r_isum + SUM_W'(i_in_data.entropy_value);
                    end else begin
                        n_osum = r_osum + SUM_W'(i_in_data.entropy_value);
                    end
                end
                if (i_in_data.last) begin
                    n_last_lvl = level;
                end else begin
                    n_out.mask_level         = level;
                    n_out.stats_valid        = 1'b0;
                    n_out.density            = '0;
                    n_out.mask_entropy_mean  = '0;
                    n_out.other_entropy_mean = '0;
                    n_out_valid = 1'b1;
                end
            end
        end

        if (i_cmd.capture) begin
            case (i_cmd.sel)
                DIV_MEASURE:  n_mmean = quot[VALUE_W-1:0];
                DIV_ENTROPY:  n_emean = quot[VALUE_W-1:0];
                DIV_DENSITY:  n_dens  = quot[DENS_W-1:0];
                DIV_IN_MEAN:  n_imean = quot[VALUE_W-1:0];
                DIV_OUT_MEAN: n_omean = quot[VALUE_W-1:0];
                default: ;
            endcase
        end

        if (i_cmd.emit_stats) begin
            n_out.mask_level         = r_last_lvl;
            n_out.stats_valid        = 1'b1;
            n_out.density            = r_dens;
            n_out.mask_entropy_mean  = r_imean;
            n_out.other_entropy_mean = r_omean;
            n_out_valid = 1'b1;
        end

        if (i_cmd.clear_acc) begin
            n_msum = '0;
            n_esum = '0;
            n_pcnt = '0;
        end
        if (i_cmd.clear_acc || i_cmd.emit_stats) begin
            n_icnt = '0;
            n_ccnt = '0;
            n_isum = '0;
            n_osum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_dens     <= n_dens;
        r_imean    <= n_imean;
        r_omean    <= n_omean;
        r_last_lvl <= n_last_lvl;
        if (!i_rst_n) begin
            r_mthr      <= RST_MEASURE_THR;
            r_ethr      <= RST_ENTROPY_THR;
            r_lvl0      <= RST_LEVEL_ZERO;
            r_lvl1      <= RST_LEVEL_ONE;
            r_msum      <= '0;
            r_esum      <= '0;
            r_pcnt      <= '0;
            r_mmean     <= '0;
            r_emean     <= '0;
            r_icnt      <= '0;
            r_ccnt      <= '0;
            r_isum      <= '0;
            r_osum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MEASURE_THR: r_mthr <= i_cfg_data[THR_W-1:0];
                    CFG_ENTROPY_THR: r_ethr <= i_cfg_data[THR_W-1:0];
                    CFG_LEVEL_ZERO:  r_lvl0 <= i_cfg_data[LEVEL_W-1:0];
                    CFG_LEVEL_ONE:   r_lvl1 <= i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            r_msum      <= n_msum;
            r_esum      <= n_esum;
            r_pcnt      <= n_pcnt;
            r_mmean     <= n_mmean;
            r_emean     <= n_emean;
            r_icnt      <= n_icnt;
            r_ccnt      <= n_ccnt;
            r_isum      <= n_isum;
            r_osum      <= n_osum;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_status.div_done  = div_done;
    assign o_status.out_ready = out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/dmtm_ctrl.sv
// pass sequencing state machine: beat intake, end of pass divisions, stats beat
module dmtm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  dmtm_pkg::t_in_beat  i_in_data,
    output logic                o_in_stall,
    input  dmtm_pkg::t_status   i_status,
    output dmtm_pkg::t_cmd      o_cmd
);
    import dmtm_pkg::*;

    t_state   r_state, n_state;
    t_div_sel r_sel, n_sel;
    logic     can_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= DIV_MEASURE;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign can_take = (r_state == S_IDLE) && i_status.out_ready;
    assign o_in_stall = !can_take;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && can_take) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_data.last) begin
                        n_state = S_DIV_LOAD;
                        n_sel   = i_in_data.func ? DIV_DENSITY : DIV_MEASURE;
                    end
                end
            end
            S_DIV_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.capture = 1'b1;
                    case (r_sel)
                        DIV_MEASURE: begin
                            n_sel   = DIV_ENTROPY;
                            n_state = S_DIV_LOAD;
                        end
                        DIV_ENTROPY: begin
                            o_cmd.clear_acc = 1'b1;
                            n_state = S_IDLE;
                        end
                        DIV_DENSITY: begin
                            n_sel   = DIV_IN_MEAN;
                            n_state = S_DIV_LOAD;
                        end
                        DIV_IN_MEAN: begin
                            n_sel   = DIV_OUT_MEAN;
                            n_state = S_DIV_LOAD;
                        end
                        DIV_OUT_MEAN: begin
                            n_state = S_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (i_status.out_ready) begin
                    o_cmd.emit_stats = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/dual_mean_threshold_mask_core.sv
// top level of the dual mean threshold mask block
//
//  channel  direction  handshake              payload
//  in       input      i_in_valid/o_in_stall  i_in_data  (t_in_beat)
//  out      output     o_out_valid/i_out_stall o_out_data (t_out_beat)
//  cfg      input      i_cfg_we               i_cfg_idx, i_cfg_data
//
// one beat per cycle while no pass ends and the output is not stalled; results wait in an output register
// a last beat starts the shared serial divider: two divisions after an
// accumulate pass, three after a classify pass, then the stats beat is
// loaded once the output frees up
// synchronous active low reset; no clearing pass, ready the cycle after reset
module dual_mean_threshold_mask_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  dmtm_pkg::t_in_beat              i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output dmtm_pkg::t_out_beat             o_out_data,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_we,
    input  logic [dmtm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmtm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dmtm_pkg::*;

    t_cmd    cmd;
    t_status status;

    dmtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dmtm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: tb/tb_dual_mean_threshold_mask_core.sv
`timescale 1ns / 100ps
// self-checking testbench for dual_mean_threshold_mask_core with a mask predictor and scoreboard
module tb_dual_mean_threshold_mask_core;
    import dmtm_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int PHASE_ITEMS   = 110;
    localparam int PENDING_DEPTH = 32;
    localparam int QUOT_W        = SUM_W + DENS_SHIFT;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_beat              in_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_beat             out_data;
    logic                  out_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_in_beat  pending[$];
    t_out_beat mask_beats_due[$];
    logic      calm = 1'b0;
    int        hold_req = 0;
    int        hold_done = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    int        fed = 0;
    int        errors = 0;

    logic [THR_W-1:0]   thr_measure, thr_entropy;
    logic [LEVEL_W-1:0] lvl_zero, lvl_one;
    logic [SUM_W-1:0]   acc_measure, acc_entropy, in_ent_sum, out_ent_sum;
    logic [CNT_W-1:0]   acc_pixels, cls_pixels, cls_inside;
    logic [VALUE_W-1:0] mean_measure, mean_entropy;

    dual_mean_threshold_mask_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [QUOT_W-1:0] quot(input logic [QUOT_W-1:0] num,
                                               input logic [CNT_W-1:0] den);
        return (den == '0) ? '0 : num / den;
    endfunction

    task automatic clear_classes();
        cls_pixels  = '0;
        cls_inside  = '0;
        in_ent_sum  = '0;
        out_ent_sum = '0;
    endtask

    task automatic mask_predict(input t_in_beat b);
        t_out_beat r;
        logic      hit;
        r = '0;
        if (!b.func) begin
            if (acc_pixels < MAX_PIXELS) begin
                acc_measure += SUM_W'(b.measure_value);
                acc_entropy += SUM_W'(b.entropy_value);
                acc_pixels++;
            end
            if (b.last) begin
                mean_measure = VALUE_W'(quot(QUOT_W'(acc_measure), acc_pixels));
                mean_entropy = VALUE_W'(quot(QUOT_W'(acc_entropy), acc_pixels));
                acc_measure  = '0;
                acc_entropy  = '0;
                acc_pixels   = '0;
                clear_classes();
            end
        end else begin
            hit = (PROD_W'({b.measure_value, 8'h00}) >=
                   PROD_W'(thr_measure) * PROD_W'(mean_measure)) &&
                  (PROD_W'({b.entropy_value, 8'h00}) >=
                   PROD_W'(thr_entropy) * PROD_W'(mean_entropy));
            if (cls_pixels < MAX_PIXELS) begin
                cls_pixels++;
                if (hit) begin
                    cls_inside++;
                    in_ent_sum += SUM_W'(b.entropy_value);
                end else begin
                    out_ent_sum += SUM_W'(b.entropy_value);
                end
            end
            r.mask_level  = hit ? lvl_one : lvl_zero;
            r.stats_valid = b.last;
            if (b.last) begin
                r.density            = DENS_W'(quot(QUOT_W'({cls_inside, 16'h0000}),
                                                    cls_pixels));
                r.mask_entropy_mean  = VALUE_W'(quot(QUOT_W'(in_ent_sum), cls_inside));
                r.other_entropy_mean = VALUE_W'(quot(QUOT_W'(out_ent_sum),
                                                     cls_pixels - cls_inside));
                clear_classes();
            end
            mask_beats_due.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [DENS_W-1:0] want,
                               input logic [DENS_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // input beat sender
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || !in_stall) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 15);
                in_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                in_data  <= pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (hold_done != hold_req) begin
            hold_done  <= hold_req;
            stall_left <= LONG_HOLD;
            out_stall  <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // scoreboard
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                mask_predict(in_data);
            end
            if (out_valid && !out_stall) begin
                if (mask_beats_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
                    errors++;
                end else begin
                    want = mask_beats_due.pop_front();
                    check_field("mask_level", DENS_W'(want.mask_level),
                                DENS_W'(out_data.mask_level));
                    check_field("stats_valid", DENS_W'(want.stats_valid),
                                DENS_W'(out_data.stats_valid));
                    check_field("density", want.density, out_data.density);
                    check_field("mask_entropy_mean", DENS_W'(want.mask_entropy_mean),
                                DENS_W'(out_data.mask_entropy_mean));
                    check_field("other_entropy_mean", DENS_W'(want.other_entropy_mean),
                                DENS_W'(out_data.other_entropy_mean));
                end
            end
        end
    end

    task automatic feed(input logic f, input logic [VALUE_W-1:0] m,
                        input logic [VALUE_W-1:0] e, input logic l);
        t_in_beat b;
        b.func          = f;
        b.measure_value = m;
        b.entropy_value = e;
        b.last          = l;
        while (pending.size() >= PENDING_DEPTH) @(negedge clk);
        pending.push_back(b);
        fed++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MEASURE_THR: thr_measure = val;
            CFG_ENTROPY_THR: thr_entropy = val;
            CFG_LEVEL_ZERO:  lvl_zero = val[LEVEL_W-1:0];
            CFG_LEVEL_ONE:   lvl_one = val[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(input logic [CFG_DATA_W-1:0] mt, input logic [CFG_DATA_W-1:0] et,
                         input logic [CFG_DATA_W-1:0] lz, input logic [CFG_DATA_W-1:0] lo);
        write_reg(CFG_MEASURE_THR, mt);
        write_reg(CFG_ENTROPY_THR, et);
        write_reg(CFG_LEVEL_ZERO, lz);
        write_reg(CFG_LEVEL_ONE, lo);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        while (pending.size() != 0 || in_valid || mask_beats_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return VALUE_W'($urandom_range(0, 2047));
            1: return $urandom_range(0, 1) ? {VALUE_W{1'b1}} : {VALUE_W{1'b0}};
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_thr();
        return ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(64, 640));
    endfunction

    // accumulate pass then classify pass, sometimes noisy or broken
    task automatic send_frame();
        int n, m, style;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat (n) begin
                feed(1'($urandom_range(0, 1)), pick_value(), pick_value(),
                     $urandom_range(0, 3) == 0);
            end
        end else begin
            for (int k = 0; k < n; k++) begin
                feed(1'b0, pick_value(), pick_value(), k == n - 1);
            end
            m = (style == 1) ? $urandom_range(1, 2 * n) : n;
            for (int k = 0; k < m; k++) begin
                if (style == 2 && $urandom_range(0, 3) == 0) begin
                    feed(1'b0, pick_value(), pick_value(), 1'b0);
                end
                feed(1'b1, pick_value(), pick_value(), (k == m - 1) && (style != 3));
            end
        end
    endtask

    initial begin
        int start;
        thr_measure  = RST_MEASURE_THR;
        thr_entropy  = RST_ENTROPY_THR;
        lvl_zero     = RST_LEVEL_ZERO;
        lvl_one      = RST_LEVEL_ONE;
        acc_measure  = '0;
        acc_entropy  = '0;
        acc_pixels   = '0;
        mean_measure = '0;
        mean_entropy = '0;
        clear_classes();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // classify before any accumulate pass, means still zero
        feed(1'b1, 16'h0000, 16'h0000, 1'b0);
        feed(1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
        feed(1'b0, 16'h0000, 16'h0000, 1'b0);
        feed(1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        feed(1'b0, 16'h0200, 16'h0100, 1'b1);
        feed(1'b1, 16'hFFFF, 16'h0000, 1'b0);
        feed(1'b1, 16'h0000, 16'hFFFF, 1'b0);
        feed(1'b0, 16'h1234, 16'h4321, 1'b0);
        feed(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        feed(1'b1, 16'h8000, 16'h8000, 1'b1);
        // one-pixel pass, then exact equality and just below it
        feed(1'b0, 16'h0100, 16'h0100, 1'b1);
        feed(1'b1, 16'h0100, 16'h0100, 1'b1);
        feed(1'b1, 16'h00FF, 16'h0100, 1'b1);
        settle();

        fed = 0;
        for (int p = 0; fed < RANDOM_ITEMS; p++) begin
            case (p)
                0: setup(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
                1: setup(16'hFFFF, 16'hFFFF, 16'h0000, 16'h00FF);
                2: setup(16'h0001, 16'hFFFF, 16'hA55A, 16'h5AA5);
                default: setup(pick_thr(), pick_thr(), CFG_DATA_W'($urandom),
                               CFG_DATA_W'($urandom));
            endcase
            if (p == 3) begin
                calm     <= 1'b1;
                hold_req <= hold_req + 1;
            end else begin
                calm <= ($urandom_range(0, 3) == 0);
            end
            start = fed;
            while (fed - start < PHASE_ITEMS) send_frame();
            settle();
        end

        // closing frame, no idling from here on
        calm <= 1'b1;
        setup(16'h0100, 16'h0080, 16'h0011, 16'h00EE);
        for (int k = 0; k < 16; k++) begin
            feed(1'b0, pick_value(), pick_value(), k == 15);
        end
        for (int k = 0; k < 20; k++) begin
            feed(1'b1, pick_value(), pick_value(), k == 19);
        end
        settle();

        if (errors == 0 && mask_beats_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dmtm_pkg.sv
rtl/dmtm_div.sv
rtl/dmtm_datapath.sv
rtl/dmtm_ctrl.sv
rtl/dual_mean_threshold_mask_core.sv
tb/tb_dual_mean_threshold_mask_core.sv
